// ----- rtl/pwm_period_prescaler_solver_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the PWM period and prescaler solver
// Both macros expect i_clk and i_rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_PRESCALER_SOLVER_TOP_MACROS_SVH
`define PWM_PERIOD_PRESCALER_SOLVER_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and helpers shared by the PWM period and prescaler solver.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_COUNT  = 65536;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int DIV_W      = 32;
    localparam int PROD_W     = 8 + CNT_W;
    localparam int NUM_DIV    = 5;
    localparam int SHIFT_W    = 3;
    localparam int STEP_W     = $clog2(DIV_W);

    localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(NUM_DIV - 1);
    localparam logic [DIV_W-1:0]   SKIP_LIM   = DIV_W'(MAX_COUNT * 256);
    localparam logic [DIV_W-1:0]   CEIL_ADD   = DIV_W'(MAX_COUNT - 1);
    localparam logic [DIV_W-1:0]   MAX_CNT_W  = DIV_W'(MAX_COUNT);
    localparam logic [DIV_W-1:0]   DUTY_FULL  = DIV_W'(255);
    localparam logic [7:0]         P_MIN      = 8'd2;
    localparam logic [7:0]         P_SLOW     = 8'd255;
    localparam logic [31:0]        SRC_CLK_RST = 32'd12000000;

    // register index
    localparam logic REG_SRC_CLK = 1'b0;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FAST = 2'd2;
    localparam logic [1:0] ST_SLOW = 2'd3;

    // divider codes
    localparam logic [2:0] DIVC_1  = 3'd4;
    localparam logic [2:0] DIVC_2  = 3'd0;
    localparam logic [2:0] DIVC_4  = 3'd1;
    localparam logic [2:0] DIVC_8  = 3'd2;
    localparam logic [2:0] DIVC_16 = 3'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START0,
        S_DIV0,
        S_TRY,
        S_CEIL,
        S_CNT,
        S_SLOW,
        S_MUL,
        S_ACH_GO,
        S_ACH,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [2:0] div_code(input logic [SHIFT_W-1:0] shift);
        logic [2:0] code;
        case (shift)
            3'd0:    code = DIVC_1;
            3'd1:    code = DIVC_2;
            3'd2:    code = DIVC_4;
            3'd3:    code = DIVC_8;
            default: code = DIVC_16;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/pwm_period_prescaler_solver_top.sv -----
// ----------------------------------------------------------------------------
// pwm_period_prescaler_solver_top
// Solves PWM prescaler, clock divider, period and compare for one request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Content
//  s_axis    in         tvalid/tready          target_hz, duty_level, channel
//  m_axis    out        tvalid/tready          register fields, achieved_hz
//  apb       in         psel/penable/pwrite    source_clock_hz at address 0
//
//  Every division runs on one shared bit-serial divider. A request needs
//  1 + 2k + 2 divisions (k = 0, 1 or 2 dividers solved), with a check of
//  each divider tried; a zero target needs no division.
//  One request is in work at a time; the next is taken once a result is
//  parked in the output register, which holds it while m_axis_tready is low.
//  Reset is synchronous and active low; source clock resets to 12 MHz.
// ----------------------------------------------------------------------------
module pwm_period_prescaler_solver_top import pps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis_tdata: target_hz[31:0], duty_level[39:32], channel[41:40], zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // m_axis_tdata: prescale_field[7:0], divider_code[10:8], period_field[26:11],
    //   compare_field[42:27], achieved_hz[74:43], channel_out[76:75],
    //   status[78:77], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state r_state, n_state;

    logic [31:0]        r_src_clk;
    logic [31:0]        r_target;
    logic [7:0]         r_duty;
    logic [1:0]         r_chan;
    logic [DIV_W-1:0]   r_q0;
    logic [DIV_W-1:0]   r_q;
    logic [SHIFT_W-1:0] r_shift;
    logic [7:0]         r_p;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         r_status;
    logic               r_zero;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_dprod;
    logic [31:0]        r_ach;
    logic [15:0]        r_cmp;
    logic               r_out_valid;
    logic [79:0]        r_out_data;

    t_div_req         div_req;
    t_div_sts         div_sts;
    logic [DIV_W-1:0] div_quo;

    logic [DIV_W-1:0] w_q;
    logic             w_skip;
    logic [7:0]       w_pp;
    logic             w_fits;
    logic             w_out_free;
    logic             w_in_acc;
    logic [79:0]      w_result;
    logic             w_div_wait;
    logic             w_out_ok;

    pps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    assign w_q        = r_q0 >> r_shift;
    assign w_skip     = w_q > SKIP_LIM;
    // a ceiling above 255 is raised to the minimum like the small ones
    assign w_pp       = (div_quo < DIV_W'(3) || div_quo > DIV_W'(255)) ? P_MIN : div_quo[7:0];
    assign w_fits     = div_quo <= MAX_CNT_W;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_div_wait = (r_state == S_DIV0) || (r_state == S_CEIL) || (r_state == S_CNT)
                        || (r_state == S_ACH) || (r_state == S_CMP);
    assign w_out_ok   = (r_state == S_OUT) && !r_zero && (r_status == ST_OK);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SRC_CLK) ? r_src_clk : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_clk <= SRC_CLK_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SRC_CLK) begin
            r_src_clk <= pwdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_START0;
            S_START0: n_state = (r_target == 32'd0) ? S_OUT : S_DIV0;
            S_DIV0:   if (div_sts.done) n_state = S_TRY;
            S_TRY: begin
                if (!w_skip)                    n_state = S_CEIL;
                else if (r_shift == LAST_SHIFT) n_state = S_SLOW;
            end
            S_CEIL:   if (div_sts.done) n_state = S_CNT;
            S_CNT: begin
                if (div_sts.done) begin
                    if (w_fits)                     n_state = S_MUL;
                    else if (r_shift == LAST_SHIFT) n_state = S_SLOW;
                    else                            n_state = S_TRY;
                end
            end
            S_SLOW:   n_state = S_MUL;
            S_MUL:    n_state = S_ACH_GO;
            S_ACH_GO: n_state = S_ACH;
            S_ACH:    if (div_sts.done) n_state = S_CMP;
            S_CMP:    if (div_sts.done) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and divider requests
    always_comb begin
        s_axis_tready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            // hold off requests while in reset
            S_IDLE: s_axis_tready = i_rst_n;
            S_START0: begin
                div_req.start    = (r_target != 32'd0);
                div_req.dividend = r_src_clk;
                div_req.divisor  = r_target;
            end
            S_TRY: begin
                div_req.start    = !w_skip;
                div_req.dividend = w_q + CEIL_ADD;
                div_req.divisor  = MAX_CNT_W;
            end
            S_CEIL: begin
                div_req.start    = div_sts.done;
                div_req.dividend = r_q;
                div_req.divisor  = {{(DIV_W-8){1'b0}}, w_pp};
            end
            S_ACH_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_src_clk;
                div_req.divisor  = DIV_W'(r_prod) << r_shift;
            end
            S_ACH: begin
                div_req.start    = div_sts.done;
                div_req.dividend = DIV_W'(r_dprod);
                div_req.divisor  = DUTY_FULL;
            end
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_target <= s_axis_tdata[31:0];
                    r_duty   <= s_axis_tdata[39:32];
                    r_chan   <= s_axis_tdata[41:40];
                end
            end
            S_START0: r_zero <= (r_target == 32'd0);
            S_DIV0: begin
                if (div_sts.done) begin
                    r_q0    <= div_quo;
                    r_shift <= '0;
                end
            end
            S_TRY: begin
                r_q <= w_q;
                if (w_skip && r_shift != LAST_SHIFT) r_shift <= r_shift + 1'b1;
            end
            S_CEIL: if (div_sts.done) r_p <= w_pp;
            S_CNT: begin
                if (div_sts.done) begin
                    if (w_fits) begin
                        // hold a count of 0 or 1 at 1 and flag it
                        if (div_quo <= DIV_W'(1)) begin
                            r_count  <= CNT_W'(1);
                            r_status <= ST_FAST;
                        end else begin
                            r_count  <= div_quo[CNT_W-1:0];
                            r_status <= ST_OK;
                        end
                    end else if (r_shift != LAST_SHIFT) begin
                        r_shift <= r_shift + 1'b1;
                    end
                end
            end
            S_SLOW: begin
                r_p      <= P_SLOW;
                r_shift  <= LAST_SHIFT;
                r_count  <= CNT_W'(MAX_COUNT);
                r_status <= ST_SLOW;
            end
            S_MUL: begin
                r_prod  <= PROD_W'(r_p * r_count);
                r_dprod <= PROD_W'(r_duty * r_count);
            end
            S_ACH: if (div_sts.done) r_ach <= div_quo;
            S_CMP: begin
                if (div_sts.done) begin
                    r_cmp <= (div_quo == '0) ? 16'd0 : 16'(div_quo - 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_result = '0;
        if (r_zero) begin
            w_result[76:75] = r_chan;
            w_result[78:77] = ST_ZERO;
        end else begin
            w_result[7:0]   = r_p - 8'd1;
            w_result[10:8]  = div_code(r_shift);
            w_result[26:11] = 16'(r_count - CNT_W'(1));
            w_result[42:27] = r_cmp;
            w_result[74:43] = r_ach;
            w_result[76:75] = r_chan;
            w_result[78:77] = r_status;
        end
    end

    // output register: park the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "pwm_period_prescaler_solver_top_macros.svh"

    `PPS_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == S_START0, "request not started")
    `PPS_ASSERT_SAME(a_done_in_wait, div_sts.done, w_div_wait, "divider result outside a wait state")
    `PPS_ASSERT_SAME(a_start_idle, div_req.start, !div_sts.busy, "divider started while busy")
    `PPS_ASSERT_NEXT(a_result_parked, r_state == S_OUT && w_out_free, m_axis_tvalid, "result not parked")
    `PPS_ASSERT_SAME(a_ok_count, w_out_ok, r_count > CNT_W'(1), "ok status with short count")

endmodule

// ----- rtl/pps_div.sv -----
// ----------------------------------------------------------------------------
// pps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div import pps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output t_div_sts         o_sts,
    output logic [DIV_W-1:0] o_quotient
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0]    w_shifted;
    logic [DIV_W:0]    w_trial;
    logic              w_ge;

    assign w_shifted = {r_rem, r_quo[DIV_W-1]};
    assign w_trial   = w_shifted - {1'b0, r_dvs};
    assign w_ge      = !w_trial[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem  <= w_ge ? w_trial[DIV_W-1:0] : w_shifted[DIV_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_step <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sim/pwm_period_prescaler_solver_top_tb.sv -----
// ----------------------------------------------------------------------------
// pwm_period_prescaler_solver_top_tb
// Streams PWM set-up requests into the solver under several source clocks,
// works out each prescaler, divider, period, compare and achieved frequency
// on the side, and checks every returned setting field by field.
// ----------------------------------------------------------------------------
module pwm_period_prescaler_solver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int          QUIET_LIMIT  = 4000;
    localparam int          TAIL_CYCLES  = 300;
    localparam logic [2:0]  SRC_CLK_ADDR = 3'(REG_SRC_CLK) * 3'd4;
    localparam longint unsigned COUNT_CAP = longint'(MAX_COUNT);

    // last field in the lowest bits
    typedef struct packed {
        logic [1:0]  channel;
        logic [7:0]  duty_level;
        logic [31:0] target_hz;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  channel_out;
        logic [31:0] achieved_hz;
        logic [15:0] compare_field;
        logic [15:0] period_field;
        logic [2:0]  divider_code;
        logic [7:0]  prescale_field;
    } t_setting;

    class pwm_setting_board;
        logic [31:0] src_clk_hz;
        t_setting    awaited_settings[$];
        int          mismatches;
        int          results_seen;
        int          requests_seen;
        int          status_seen[4];

        function new();
            src_clk_hz    = SRC_CLK_RST;
            mismatches    = 0;
            results_seen  = 0;
            requests_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return awaited_settings.size();
        endfunction

        function t_setting solve_setting(t_request r);
            t_setting        s;
            longint unsigned ratio, q, pp, c, p, cnt, div, ach, v;
            logic [1:0]      st;
            bit              found;
            s = '0;
            s.channel_out = r.channel;
            if (r.target_hz == 0) begin
                s.status = ST_ZERO;
                return s;
            end
            p     = 255;
            cnt   = COUNT_CAP;
            div   = 16;
            st    = ST_SLOW;
            found = 0;
            ratio = longint'(src_clk_hz) / longint'(r.target_hz);
            for (int shift = 0; shift < 5 && !found; shift++) begin
                q = ratio >> shift;
                if (q <= COUNT_CAP * 256) begin
                    // ceiling is kept to 8 bits, so 256 wraps to 0 and is lifted to 2
                    pp = ((q + COUNT_CAP - 1) / COUNT_CAP) & 64'hFF;
                    if (pp < 3) pp = 2;
                    c = q / pp;
                    if (c <= COUNT_CAP) begin
                        found = 1;
                        p     = pp;
                        div   = 64'd1 << shift;
                        if (c <= 1) begin
                            cnt = 1;
                            st  = ST_FAST;
                        end else begin
                            cnt = c;
                            st  = ST_OK;
                        end
                    end
                end
            end
            ach = longint'(src_clk_hz) / (p * div * cnt);
            if (r.duty_level == 0) begin
                v = 0;
            end else begin
                v = (longint'(r.duty_level) * cnt) / 255;
                if (v != 0) v = v - 1;
            end
            case (div)
                1:       s.divider_code = DIVC_1;
                2:       s.divider_code = DIVC_2;
                4:       s.divider_code = DIVC_4;
                8:       s.divider_code = DIVC_8;
                default: s.divider_code = DIVC_16;
            endcase
            s.prescale_field = 8'(p - 1);
            s.period_field   = 16'(cnt - 1);
            s.compare_field  = 16'(v);
            s.achieved_hz    = 32'(ach);
            s.status         = st;
            return s;
        endfunction

        function void note_request(t_request r);
            requests_seen++;
            awaited_settings.push_back(solve_setting(r));
        endfunction

        function void compare_one(string name, logic [63:0] want, logic [63:0] got);
            if (want === got) return;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s in result %0d: expected 0x%0h, got 0x%0h",
                         name, results_seen, want, got);
        endfunction

        function void check_result(logic [79:0] data);
            t_setting want, got;
            got = t_setting'(data[78:0]);
            results_seen++;
            if (awaited_settings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unrequested result %0d: 0x%0h", results_seen, data);
                return;
            end
            want = awaited_settings.pop_front();
            status_seen[want.status]++;
            compare_one("prescale_field", want.prescale_field, got.prescale_field);
            compare_one("divider_code",   want.divider_code,   got.divider_code);
            compare_one("period_field",   want.period_field,   got.period_field);
            compare_one("compare_field",  want.compare_field,  got.compare_field);
            compare_one("achieved_hz",    want.achieved_hz,    got.achieved_hz);
            compare_one("channel_out",    want.channel_out,    got.channel_out);
            compare_one("status",         want.status,         got.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // s_axis_tdata: target_hz, duty_level, channel, zero pad (lowest first)
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // m_axis_tdata: prescale_field, divider_code, period_field, compare_field,
    //   achieved_hz, channel_out, status, zero pad (lowest first)
    logic [79:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pwm_setting_board board = new();
    bit               idle_on;
    int               quiet_cycles;
    int               phases_run;

    pwm_period_prescaler_solver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // give up once nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, board.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, then take and check each setting
    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            board.check_result(m_axis_tdata);
        end
    end

    task automatic write_src_clock(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SRC_CLK_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.src_clk_hz = value;
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // hold valid across back-to-back requests, drop it ahead of a gap or after the last
    task automatic send_requests(input t_request reqs[$]);
        int gap, next_gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        foreach (reqs[i]) begin
            repeat (gap) @(posedge i_clk);
            next_gap = idle_on ? $urandom_range(0, 3) : 0;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'b0, reqs[i]};
            do @(posedge i_clk); while (s_axis_tready !== 1'b1);
            board.note_request(reqs[i]);
            if (next_gap > 0 || i == reqs.size() - 1) s_axis_tvalid <= 1'b0;
            gap = next_gap;
        end
    endtask

    function automatic t_request random_request(input logic [31:0] clk_hz);
        t_request        r;
        int unsigned     pick, e;
        longint unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r.target_hz = '0;
        end else if (pick < 20) begin
            r.target_hz = $urandom;
        end else if (pick < 45) begin
            // land near the prescaler and count boundaries of this clock
            case ($urandom_range(0, 7))
                0:       k = 1;
                1:       k = 2;
                2:       k = 65536;
                3:       k = 131072;
                4:       k = 65536 * 255;
                5:       k = 64'd1 << 24;
                6:       k = 64'd1 << 25;
                default: k = 64'd1 << 28;
            endcase
            k = k + $urandom_range(0, 6);
            k = (k > 3) ? k - 3 : 1;
            r.target_hz = 32'(longint'(clk_hz) / k);
            if (r.target_hz == 0) r.target_hz = 32'd1;
        end else begin
            e = $urandom_range(0, 31);
            r.target_hz = ($urandom >> (31 - e)) | (32'd1 << e);
        end
        case ($urandom_range(0, 9))
            0:       r.duty_level = 8'd0;
            1:       r.duty_level = 8'd255;
            default: r.duty_level = 8'($urandom_range(0, 255));
        endcase
        r.channel = 2'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic run_phase(input bit do_write, input logic [31:0] clk_hz,
                             input bit with_directed, input int n_random);
        t_request   reqs[$];
        t_request   r;
        logic [7:0] duties[4];
        duties = '{8'd0, 8'd255, 8'd1, 8'd128};
        if (do_write) write_src_clock(clk_hz);
        phases_run++;
        for (int b = 0; b < 2; b++) begin
            reqs.delete();
            if (b == 0 && with_directed) begin
                for (int i = 0; i < 12; i++) begin
                    case (i)
                        0:       r.target_hz = '0;
                        1:       r.target_hz = 32'd1;
                        2:       r.target_hz = '1;
                        3:       r.target_hz = clk_hz;
                        4:       r.target_hz = clk_hz / 2;
                        5:       r.target_hz = clk_hz / 3;
                        6:       r.target_hz = clk_hz / 65536;
                        7:       r.target_hz = clk_hz / 65537;
                        8:       r.target_hz = clk_hz / (65536 * 256);
                        9:       r.target_hz = 32'd256;
                        10:      r.target_hz = clk_hz / (65536 * 255 + 1);
                        default: r.target_hz = 32'd1000;
                    endcase
                    if (i > 0 && r.target_hz == 0) r.target_hz = 32'd1;
                    r.duty_level = duties[(i + i / 4) % 4];
                    r.channel    = 2'(i);
                    reqs.push_back(r);
                end
            end
            for (int i = 0; i < n_random / 2; i++) reqs.push_back(random_request(clk_hz));
            idle_on = ($urandom_range(0, 3) != 0);
            send_requests(reqs);
            // hold off until every outstanding setting is back
            wait_for_results();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_on       = 1'b1;
        quiet_cycles  = 0;
        phases_run    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(1'b0, SRC_CLK_RST, 1'b1, 120);
        run_phase(1'b1, '1, 1'b1, 140);
        run_phase(1'b1, 32'd1, 1'b0, 80);
        run_phase(1'b1, 32'd0, 1'b0, 80);
        run_phase(1'b1, SRC_CLK_RST, 1'b0, 160);
        for (int i = 0; i < 6; i++)
            run_phase(1'b1, (i % 2 == 0) ? $urandom : $urandom_range(1000000, 200000000),
                      1'b0, 150);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over %0d source clock settings, %0d mismatches",
                 board.requests_seen, phases_run, board.mismatches);
        $display("results by outcome: ok %0d, zero %0d, too fast %0d, too slow %0d",
                 board.status_seen[ST_OK], board.status_seen[ST_ZERO],
                 board.status_seen[ST_FAST], board.status_seen[ST_SLOW]);
        if (board.pending() != 0)
            $display("%0d settings never returned", board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
